/* rtl/dual_motor_velocity_ramp_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the dual motor velocity ramp unit
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef DUAL_MOTOR_VELOCITY_RAMP_UNIT_MACROS_SVH
`define DUAL_MOTOR_VELOCITY_RAMP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DMVR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dmvr assertion failed");
// next-cycle implication
`define DMVR_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dmvr assertion failed");
`else
`define DMVR_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define DMVR_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

/* rtl/dmvr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmvr_pkg
// Commands, sequencer states and velocity helpers shared by the ramp unit.
// ---------------------------------------------------------------------------
package dmvr_pkg;

  localparam int VelBits   = 8;
  localparam int QuotBits  = 7;
  localparam int QidxBits  = 3;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_RAMP  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_PUSH
  } seq_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL0,
    U_MUL1,
    U_ABS,
    U_DIV,
    U_DONE
  } unit_phase_t;

  // Saturate a 16-bit velocity to -100..100.
  function automatic logic signed [VelBits-1:0] sat_vel(input logic signed [15:0] v);
    logic signed [VelBits-1:0] r;
    if (v > 16'sd100) begin
      r = 8'sd100;
    end else if (v < -16'sd100) begin
      r = -8'sd100;
    end else begin
      r = v[VelBits-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/dmvr_interp.sv */
`timescale 1ns / 1ps
`include "dual_motor_velocity_ramp_unit_macros.svh"
// ---------------------------------------------------------------------------
// dmvr_interp
// Iterative interpolator: one shared multiplier builds start*L + e*(end-start)
// in MUL0 and MUL1, then a restoring divider takes one quotient bit a cycle.
// ---------------------------------------------------------------------------
module dmvr_interp #(
  parameter int DURATION_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [dmvr_pkg::VelBits-1:0]  start_vel,
  input  logic signed [dmvr_pkg::VelBits-1:0]  end_vel,
  input  logic        [DURATION_BITS-1:0]      length,
  input  logic        [DURATION_BITS-1:0]      elapsed,
  output logic                                 done,
  output logic signed [dmvr_pkg::VelBits-1:0]  velocity
);
  import dmvr_pkg::*;

  localparam int AW = DURATION_BITS + 10;
  localparam int RW = DURATION_BITS + 8;

  unit_phase_t phase, phase_next;

  logic signed [VelBits-1:0]   op_start;
  logic signed [VelBits:0]     op_delta;
  logic        [DURATION_BITS-1:0] op_len;
  logic        [DURATION_BITS-1:0] op_elapsed;
  logic signed [AW-1:0]        acc;
  logic        [RW-1:0]        rem;
  logic        [QuotBits-1:0]  quot;
  logic        [QidxBits-1:0]  bit_idx;
  logic                        neg;

  logic signed [VelBits:0]         mul_a;
  logic signed [DURATION_BITS:0]   mul_b;
  logic signed [AW-1:0]            product;
  logic signed [AW-1:0]            mag;
  logic        [RW-1:0]            div_sh;
  logic        [RW:0]              trial;
  logic        [VelBits-1:0]       quot_ext;

  // Shared multiplier operand select
  assign mul_a   = (phase == U_MUL0) ? {op_start[VelBits-1], op_start} : op_delta;
  assign mul_b   = $signed({1'b0, (phase == U_MUL0) ? op_len : op_elapsed});
  assign product = mul_a * mul_b;

  // Magnitude and one restoring division step
  assign mag    = acc[AW-1] ? -acc : acc;
  assign div_sh = {8'b0, op_len} << bit_idx;
  assign trial  = {1'b0, rem} - {1'b0, div_sh};

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      U_IDLE: if (start) phase_next = U_MUL0;
      U_MUL0: phase_next = U_MUL1;
      U_MUL1: phase_next = U_ABS;
      U_ABS:  phase_next = U_DIV;
      U_DIV:  if (bit_idx == '0) phase_next = U_DONE;
      U_DONE: phase_next = U_IDLE;
      default: phase_next = U_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    quot_ext = {1'b0, quot};
    done     = (phase == U_DONE);
    velocity = neg ? $signed(8'd0 - quot_ext) : $signed(quot_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= U_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (phase)
      U_IDLE: begin
        if (start) begin
          op_start   <= start_vel;
          op_delta   <= {end_vel[VelBits-1], end_vel} - {start_vel[VelBits-1], start_vel};
          op_len     <= length;
          op_elapsed <= elapsed;
        end
      end
      U_MUL0: acc <= product;
      U_MUL1: acc <= acc + product;
      U_ABS: begin
        neg     <= acc[AW-1];
        rem     <= mag[RW-1:0];
        quot    <= '0;
        bit_idx <= QidxBits'(QuotBits - 1);
      end
      U_DIV: begin
        if (!trial[RW]) begin
          rem           <= trial[RW-1:0];
          quot[bit_idx] <= 1'b1;
        end
        bit_idx <= bit_idx - 1'b1;
      end
      default: ;
    endcase
  end

  `DMVR_ASSERT_IMP(a_quot_range, clk, rst, done, quot <= 7'd100)
  `DMVR_ASSERT_IMP(a_start_idle, clk, rst, start, phase == U_IDLE)
  `DMVR_ASSERT_NXT(a_div_to_done, clk, rst, phase == U_DIV && bit_idx == '0, phase == U_DONE)

endmodule

/* rtl/dual_motor_velocity_ramp_unit.sv */
`timescale 1ns / 1ps
`include "dual_motor_velocity_ramp_unit_macros.svh"
// ---------------------------------------------------------------------------
// dual_motor_velocity_ramp_unit
// Two-motor velocity ramp generator with H-bridge direction and duty output.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | command motor_sel start_velocity
//          |                     | end_velocity duration_ticks
//  out     | out_valid/out_ready | motor_out duty_percent dir_in1 dir_in2
//          |                     | applied_velocity last_result
//
//  Set and ramp requests go from idle to the push state. A tick scans each
//  running ramp through the interpolator (multiply phases MUL0 and MUL1, a
//  magnitude phase, seven divide steps, a done phase) and pushes its result.
//  Abort returns to idle without pushing a result.
//  Synchronous reset stops both ramps at once; there is no clearing pass.
//  A stalled output register holds the sequencer until the result is taken.
// ---------------------------------------------------------------------------
module dual_motor_velocity_ramp_unit #(
  parameter int DURATION_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic                                motor_sel,
  input  logic signed [15:0]                  start_velocity,
  input  logic signed [15:0]                  end_velocity,
  input  logic [23:0]                         duration_ticks,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                motor_out,
  output logic [6:0]                          duty_percent,
  output logic                                dir_in1,
  output logic                                dir_in2,
  output logic signed [dmvr_pkg::VelBits-1:0] applied_velocity,
  output logic                                last_result
);
  import dmvr_pkg::*;

  seq_state_t state, state_next;

  // Per-motor ramp state
  logic signed [VelBits-1:0]     ramp_start   [2];
  logic signed [VelBits-1:0]     ramp_end     [2];
  logic        [DURATION_BITS-1:0] ramp_length  [2];
  logic        [DURATION_BITS-1:0] ramp_elapsed [2];
  logic        [1:0]             ramp_active;

  logic                          cur_motor;
  logic                          tick_cmd;
  logic                          pend_motor;
  logic signed [VelBits-1:0]     pend_vel;
  logic                          pend_last;

  cmd_t                          cmd;
  logic                          accept;
  logic signed [VelBits-1:0]     sv;
  logic signed [VelBits-1:0]     ev;
  logic [DURATION_BITS+23:0]     dur_wide;
  logic [DURATION_BITS-1:0]      dur_l;
  logic                          instant;
  logic [DURATION_BITS-1:0]      e_inc;
  logic                          reached;
  logic [DURATION_BITS-1:0]      e_new;
  logic                          push_ok;
  logic                          push;
  logic                          unit_start;
  logic                          unit_done;
  logic signed [VelBits-1:0]     unit_vel;
  logic [VelBits-1:0]            pend_abs;

  // Decode the request
  assign cmd      = cmd_t'(command);
  assign accept   = in_valid && in_ready;
  assign sv       = sat_vel(start_velocity);
  assign ev       = sat_vel(end_velocity);
  assign dur_wide = {{DURATION_BITS{1'b0}}, duration_ticks};
  assign dur_l    = dur_wide[DURATION_BITS-1:0];
  assign instant  = (sv == ev) || (dur_l == '0);

  // Advance the elapsed count of the scanned motor
  assign e_inc   = ramp_elapsed[cur_motor] + 1'b1;
  assign reached = (e_inc >= ramp_length[cur_motor]);
  assign e_new   = reached ? ramp_length[cur_motor] : e_inc;

  assign push_ok  = !out_valid || out_ready;
  assign pend_abs = pend_vel[VelBits-1] ? (8'd0 - pend_vel) : pend_vel;

  dmvr_interp #(
    .DURATION_BITS(DURATION_BITS)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .start     (unit_start),
    .start_vel (ramp_start[cur_motor]),
    .end_vel   (ramp_end[cur_motor]),
    .length    (ramp_length[cur_motor]),
    .elapsed   (e_new),
    .done      (unit_done),
    .velocity  (unit_vel)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_SET, CMD_RAMP: state_next = S_PUSH;
            CMD_TICK:          state_next = S_SCAN;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (ramp_active[cur_motor]) begin
          state_next = S_CALC;
        end else if (cur_motor) begin
          state_next = S_IDLE;
        end
      end
      S_CALC: if (unit_done) state_next = S_PUSH;
      S_PUSH: begin
        if (push_ok) begin
          state_next = (tick_cmd && !cur_motor) ? S_SCAN : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready   = (state == S_IDLE);
    unit_start = (state == S_SCAN) && ramp_active[cur_motor];
    push       = (state == S_PUSH) && push_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ramp state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_active <= '0;
      cur_motor   <= 1'b0;
      tick_cmd    <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        ramp_start[k]   <= '0;
        ramp_end[k]     <= '0;
        ramp_length[k]  <= '0;
        ramp_elapsed[k] <= '0;
      end
    end else begin
      if (accept) begin
        tick_cmd  <= (cmd == CMD_TICK);
        cur_motor <= (cmd == CMD_TICK) ? 1'b0 : motor_sel;
        case (cmd)
          CMD_SET: ramp_active[motor_sel] <= 1'b0;
          CMD_RAMP: begin
            if (instant) begin
              ramp_active[motor_sel] <= 1'b0;
            end else begin
              ramp_start[motor_sel]   <= sv;
              ramp_end[motor_sel]     <= ev;
              ramp_length[motor_sel]  <= dur_l;
              ramp_elapsed[motor_sel] <= '0;
              ramp_active[motor_sel]  <= 1'b1;
            end
          end
          CMD_TICK: ;
          default: ramp_active <= '0;
        endcase
      end
      if (state == S_SCAN) begin
        if (ramp_active[cur_motor]) begin
          ramp_elapsed[cur_motor] <= e_new;
          if (reached) ramp_active[cur_motor] <= 1'b0;
        end else begin
          cur_motor <= 1'b1;
        end
      end
      if (push && tick_cmd && !cur_motor) begin
        cur_motor <= 1'b1;
      end
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_motor <= motor_sel;
      pend_last  <= 1'b1;
      pend_vel   <= (cmd == CMD_RAMP && instant) ? ev : sv;
    end
    if (state == S_SCAN && ramp_active[cur_motor]) begin
      pend_motor <= cur_motor;
      pend_last  <= cur_motor || !ramp_active[1];
    end
    if (state == S_CALC && unit_done) begin
      pend_vel <= unit_vel;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      motor_out        <= pend_motor;
      duty_percent     <= pend_abs[6:0];
      dir_in1          <= pend_vel[VelBits-1];
      dir_in2          <= !pend_vel[VelBits-1];
      applied_velocity <= pend_vel;
      last_result      <= pend_last;
    end
  end

  `DMVR_ASSERT_IMP(a_ramp_a_in_range, clk, rst, ramp_active[0], ramp_elapsed[0] < ramp_length[0])
  `DMVR_ASSERT_IMP(a_ramp_b_in_range, clk, rst, ramp_active[1], ramp_elapsed[1] < ramp_length[1])
  `DMVR_ASSERT_NXT(a_push_holds, clk, rst, state == S_PUSH && out_valid && !out_ready, state == S_PUSH)

endmodule
